>>> rtl/vpnp_pkg.sv
// Package for the VBI picture number pairer: field record type, source codes
// and VBI code word constants. No dependencies.
`timescale 1ns / 1ps

package vpnp_pkg;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_CLV  = 2'd1,
		SRC_CAV  = 2'd2
	} src_t;

	typedef struct packed {
		logic [20:0] num;
		src_t        src;
		logic        lead;
	} field_rec_t;

	localparam int          QUEUE_DEPTH   = 4;

	localparam logic [3:0]  WORD_MARK_HI  = 4'hF;
	localparam logic [7:0]  HM_MARK_MID   = 8'hDD;
	localparam logic [3:0]  TC_MARK_HI    = 4'h8;
	localparam logic [3:0]  TC_MARK_MID   = 4'hE;
	localparam logic [3:0]  TC_TENS_BASE  = 4'hA;
	localparam logic [23:0] LEAD_IN_CODE  = 24'h88FFFF;
	localparam logic [23:0] LEAD_OUT_CODE = 24'h80EEEE;
	localparam logic [4:0]  FPS_PAL       = 5'd25;
	localparam logic [4:0]  FPS_NTSC      = 5'd30;

	localparam logic [0:0]  REG_FORMAT_IS_PAL = 1'b0;

endpackage

>>> rtl/vpnp_front.sv
// Front end: decodes one field's VBI words into a field record.
// Depends on vpnp_pkg.
`timescale 1ns / 1ps

module vpnp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 format_is_pal,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [71:0]          in_data,
	input  logic                 in_present,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vpnp_pkg::field_rec_t out_rec
);
	import vpnp_pkg::*;

	function automatic logic digit_ok(input logic [3:0] d);
		return d <= 4'd9;
	endfunction

	function automatic logic cav_ok(input logic [23:0] w);
		return (w[23:20] == WORD_MARK_HI) && digit_ok({1'b0, w[18:16]}) &&
			digit_ok(w[15:12]) && digit_ok(w[11:8]) && digit_ok(w[7:4]) &&
			digit_ok(w[3:0]);
	endfunction

	function automatic logic [16:0] cav_value(input logic [23:0] w);
		return 17'(w[18:16]) * 17'd10000 + 17'(w[15:12]) * 17'd1000 +
			17'(w[11:8]) * 17'd100 + 17'(w[7:4]) * 17'd10 + 17'(w[3:0]);
	endfunction

	function automatic logic hm_ok(input logic [23:0] w);
		return (w[23:20] == WORD_MARK_HI) && (w[15:8] == HM_MARK_MID) &&
			digit_ok(w[19:16]) && (w[7:4] <= 4'd5) && digit_ok(w[3:0]);
	endfunction

	logic [23:0] v16, v17, v18;
	logic        cav17, cav18, hm17, hm18, tc_ok, lead_any;
	logic [23:0] hm_word;
	logic [6:0]  minutes;
	logic [5:0]  seconds;
	logic [15:0] secs_day;
	logic [4:0]  pic;
	logic        advance;

	logic        valid_s1;
	logic        cav_ok_s1, clv_ok_s1, lead_s1;
	logic [16:0] cav_num_s1;
	logic [15:0] secs_s1;
	logic [4:0]  pic_s1;

	logic [4:0]  fps;
	logic [20:0] total;

	assign v16 = in_data[23:0];
	assign v17 = in_data[47:24];
	assign v18 = in_data[71:48];

	always_comb begin
		cav17    = cav_ok(v17);
		cav18    = cav_ok(v18);
		hm17     = hm_ok(v17);
		hm18     = hm_ok(v18);
		hm_word  = hm17 ? v17 : v18;
		tc_ok    = (v16[23:20] == TC_MARK_HI) && (v16[15:12] == TC_MARK_MID) &&
			(v16[19:16] >= TC_TENS_BASE) && digit_ok(v16[11:8]) &&
			(v16[7:4] <= 4'd2) && digit_ok(v16[3:0]);
		minutes  = 7'(hm_word[7:4]) * 7'd10 + 7'(hm_word[3:0]);
		seconds  = 6'(v16[19:16] - TC_TENS_BASE) * 6'd10 + 6'(v16[11:8]);
		secs_day = 16'(hm_word[19:16]) * 16'd3600 + 16'(minutes) * 16'd60 +
			16'(seconds);
		pic      = 5'(v16[7:4]) * 5'd10 + 5'(v16[3:0]);
		lead_any = (v17 == LEAD_IN_CODE) || (v18 == LEAD_IN_CODE) ||
			(v17 == LEAD_OUT_CODE) || (v18 == LEAD_OUT_CODE);
	end

	assign in_ready = !valid_s1 || out_ready;
	assign advance  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cav_ok_s1  <= in_present && (cav17 || cav18);
			cav_num_s1 <= cav17 ? cav_value(v17) : cav_value(v18);
			clv_ok_s1  <= in_present && (hm17 || hm18) && tc_ok;
			lead_s1    <= in_present && lead_any;
			secs_s1    <= secs_day;
			pic_s1     <= pic;
		end
	end

	assign fps   = format_is_pal ? FPS_PAL : FPS_NTSC;
	assign total = 21'(secs_s1) * 21'(fps) + 21'(pic_s1);

	always_comb begin
		if (cav_ok_s1) begin
			out_rec.num  = 21'(cav_num_s1);
			out_rec.src  = SRC_CAV;
			out_rec.lead = lead_s1 || (cav_num_s1 == 17'd0);
		end else if (clv_ok_s1 && (total != 21'd0)) begin
			out_rec.num  = total;
			out_rec.src  = SRC_CLV;
			out_rec.lead = lead_s1;
		end else begin
			out_rec.num  = 21'd0;
			out_rec.src  = SRC_NONE;
			out_rec.lead = lead_s1;
		end
	end

	assign out_valid = valid_s1;

endmodule

>>> rtl/vpnp_queue.sv
// Short queue of decoded field records between front and back end.
// Depends on vpnp_pkg.
`timescale 1ns / 1ps

module vpnp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  vpnp_pkg::field_rec_t wr_rec,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output vpnp_pkg::field_rec_t rd_rec
);
	import vpnp_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	field_rec_t          store_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                push, pop;

	assign wr_ready = count_q != CNT_BITS'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_rec   = store_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) store_q[wr_ptr_q] <= wr_rec;
	end

endmodule

>>> rtl/vpnp_back.sv
// Back end: pairs field records, keeps the disc tallies and the frame counter,
// and holds the result register. Depends on vpnp_pkg.
`timescale 1ns / 1ps

module vpnp_back #(
	parameter int TALLY_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vpnp_pkg::field_rec_t in_rec,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [47:0]          m_tdata,
	output logic [1:0]           m_tuser
);
	import vpnp_pkg::*;

	logic                  pending_q;
	field_rec_t            held_q;
	logic [23:0]           pair_cnt_q;
	logic [TALLY_BITS-1:0] cav_tally_q, clv_tally_q, cav_next, clv_next;

	logic                  out_valid_q;
	logic [23:0]           out_index_q;
	logic [20:0]           out_num_q;
	src_t                  out_src_q;
	logic                  out_dis_q, out_lead_q, out_cav_q;

	logic                  pop;
	logic [20:0]           pick_num;
	src_t                  pick_src;
	logic                  disagree;

	assign in_ready = !out_valid_q || m_tready;
	assign pop      = in_valid && in_ready;

	always_comb begin
		cav_next = cav_tally_q;
		clv_next = clv_tally_q;
		if (in_rec.src == SRC_CAV && cav_tally_q != '1) cav_next = cav_tally_q + 1'b1;
		if (in_rec.src == SRC_CLV && clv_tally_q != '1) clv_next = clv_tally_q + 1'b1;
	end

	always_comb begin
		if (held_q.src == SRC_CAV) begin
			pick_num = held_q.num;
			pick_src = SRC_CAV;
		end else if (in_rec.src == SRC_CAV) begin
			pick_num = in_rec.num;
			pick_src = SRC_CAV;
		end else if (held_q.src == SRC_CLV) begin
			pick_num = held_q.num;
			pick_src = SRC_CLV;
		end else if (in_rec.src == SRC_CLV) begin
			pick_num = in_rec.num;
			pick_src = SRC_CLV;
		end else begin
			pick_num = 21'd0;
			pick_src = SRC_NONE;
		end
		disagree = (held_q.src != SRC_NONE) && (in_rec.src != SRC_NONE) &&
			(held_q.num != in_rec.num);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			pair_cnt_q  <= '0;
			cav_tally_q <= '0;
			clv_tally_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cav_tally_q <= cav_next;
				clv_tally_q <= clv_next;
				pending_q   <= !pending_q;
				if (pending_q) pair_cnt_q <= pair_cnt_q + 1'b1;
			end
			if (pop && pending_q) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !pending_q) held_q <= in_rec;
		if (pop && pending_q) begin
			out_index_q <= pair_cnt_q;
			out_num_q   <= pick_num;
			out_src_q   <= pick_src;
			out_dis_q   <= disagree;
			out_lead_q  <= held_q.lead || in_rec.lead;
			out_cav_q   <= cav_next > clv_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_cav_q, out_lead_q, out_dis_q, out_num_q, out_index_q};
	assign m_tuser  = out_src_q;

`ifndef ASSERT_OFF
	a_tally_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (cav_tally_q >= $past(cav_tally_q)) && (clv_tally_q >= $past(clv_tally_q)))
		else $error("disc tally decreased");

	a_pending_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(pending_q) && $stable(pair_cnt_q))
		else $error("pairing state moved without a record");

	a_result_from_pair: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pending_q) && !pending_q)
		else $error("result issued without a completed pair");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_src_q == SRC_NONE) |-> (out_num_q == 21'd0) && !out_dis_q)
		else $error("picture number set without a source");
`endif

endmodule

>>> rtl/vbi_picture_number_pairer_top.sv
// Channel     | Dir | Signals                        | Contents
// s_axis      | in  | s_tvalid s_tready s_tdata/user | one field's VBI words, presence flag
// m_axis      | out | m_tvalid m_tready m_tdata/user | one frame result per field pair
// apb config  | in  | psel penable pwrite paddr ...  | format_is_pal at byte address 0
//
// One field per clock while s_tready is high. After the second field of a pair is
// accepted, the result passes decode register, four-entry queue, result register.
// The queue lets the decoder keep taking fields while the result is stalled, until it fills.
// Reset clears the pairing, frame counter and tallies and selects 25 fps.
// Depends on vpnp_pkg, vpnp_front, vpnp_queue, vpnp_back.
`timescale 1ns / 1ps

module vbi_picture_number_pairer_top #(
	parameter int TALLY_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // line16_word, line17_word, line18_word
	input  logic        s_tuser,  // vbi_present
	output logic        m_tvalid,
	input  logic        m_tready,
	// frame_index, pic_number, fields_disagree, lead_in_or_out, disc_is_cav
	output logic [47:0] m_tdata,
	output logic [1:0]  m_tuser,  // number_source
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import vpnp_pkg::*;

	logic       pal_q;
	logic       fr_valid, fr_ready, bk_valid, bk_ready;
	field_rec_t fr_rec, bk_rec;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FORMAT_IS_PAL) ? {31'd0, pal_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_q <= 1'b1;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == REG_FORMAT_IS_PAL)) begin
			pal_q <= pwdata[0];
		end
	end

	vpnp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.format_is_pal (pal_q),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_data       (s_tdata),
		.in_present    (s_tuser),
		.out_valid     (fr_valid),
		.out_ready     (fr_ready),
		.out_rec       (fr_rec)
	);

	vpnp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_rec   (fr_rec),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready),
		.rd_rec   (bk_rec)
	);

	vpnp_back #(
		.TALLY_BITS (TALLY_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bk_valid),
		.in_ready (bk_ready),
		.in_rec   (bk_rec),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
